[rtl/alu8_pkg.sv]
// ----------------------------------------------------------------------------
// alu8_pkg
// Operation codes, flag positions and request/result types of the 8-bit ALU.
// ----------------------------------------------------------------------------
package alu8_pkg;

    // Operation codes
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBC  = 5'd3;
    localparam logic [4:0] OP_AND  = 5'd4;
    localparam logic [4:0] OP_XOR  = 5'd5;
    localparam logic [4:0] OP_OR   = 5'd6;
    localparam logic [4:0] OP_CP   = 5'd7;
    localparam logic [4:0] OP_INC  = 5'd8;
    localparam logic [4:0] OP_DEC  = 5'd9;
    localparam logic [4:0] OP_RLCA = 5'd10;
    localparam logic [4:0] OP_RLA  = 5'd11;
    localparam logic [4:0] OP_RRCA = 5'd12;
    localparam logic [4:0] OP_RRA  = 5'd13;
    localparam logic [4:0] OP_RLC  = 5'd14;
    localparam logic [4:0] OP_RRC  = 5'd15;
    localparam logic [4:0] OP_RL   = 5'd16;
    localparam logic [4:0] OP_RR   = 5'd17;
    localparam logic [4:0] OP_SLA  = 5'd18;
    localparam logic [4:0] OP_SRA  = 5'd19;
    localparam logic [4:0] OP_SWAP = 5'd20;
    localparam logic [4:0] OP_SRL  = 5'd21;
    localparam logic [4:0] OP_BIT  = 5'd22;
    localparam logic [4:0] OP_RES  = 5'd23;
    localparam logic [4:0] OP_SET  = 5'd24;
    localparam logic [4:0] OP_DAA  = 5'd25;
    localparam logic [4:0] OP_CPL  = 5'd26;
    localparam logic [4:0] OP_CCF  = 5'd27;
    localparam logic [4:0] OP_SCF  = 5'd28;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decimal adjust constants
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_MAX = 8'h99;
    localparam logic [3:0] DAA_LO_MAX = 4'h9;

    // Stream widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    typedef struct packed {
        logic [2:0] bit_index;
        logic [3:0] flags_in;
        logic [7:0] operand;
        logic [7:0] acc;
        logic [4:0] req_type;
    } alu8_req_t;

    typedef struct packed {
        logic       result_to_acc;
        logic       writes_result;
        logic [3:0] flags_out;
        logic [7:0] result;
    } alu8_res_t;

endpackage

[rtl/alu8_core.sv]
// ----------------------------------------------------------------------------
// alu8_core
// Combinational datapath: arithmetic, logic, shift/rotate, bit ops and DAA.
// ----------------------------------------------------------------------------
module alu8_core (
    input  alu8_pkg::alu8_req_t req,
    output alu8_pkg::alu8_res_t res
);
    import alu8_pkg::*;

    logic       fz, fn, fh, fc;
    logic       cin;
    logic [8:0] add_sum;
    logic [4:0] add_half;
    logic [8:0] sub_diff;
    logic [4:0] sub_half;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] sh_src;
    logic [7:0] sh_val;
    logic       sh_co;
    logic [7:0] bit_mask;
    logic [7:0] daa_t1;
    logic [7:0] daa_val;
    logic       daa_c;

    assign fz = req.flags_in[FLAG_Z];
    assign fn = req.flags_in[FLAG_N];
    assign fh = req.flags_in[FLAG_H];
    assign fc = req.flags_in[FLAG_C];

    // carry/borrow in only for ADC and SBC
    assign cin = fc && (req.req_type == OP_ADC || req.req_type == OP_SBC);

    // adder and subtractor with half-carry taps
    assign add_sum  = {1'b0, req.acc} + {1'b0, req.operand} + {8'd0, cin};
    assign add_half = {1'b0, req.acc[3:0]} + {1'b0, req.operand[3:0]} + {4'd0, cin};
    assign sub_diff = {1'b0, req.acc} - {1'b0, req.operand} - {8'd0, cin};
    assign sub_half = {1'b0, req.acc[3:0]} - {1'b0, req.operand[3:0]} - {4'd0, cin};

    assign inc_val = req.operand + 8'd1;
    assign dec_val = req.operand - 8'd1;

    assign bit_mask = 8'd1 << req.bit_index;

    // shifter source: accumulator rotates use acc, prefixed ones the target
    assign sh_src = (req.req_type <= OP_RRA) ? req.acc : req.operand;

    always_comb begin
        sh_co  = 1'b0;
        sh_val = sh_src;
        case (req.req_type)
            OP_RLCA, OP_RLC: begin
                sh_co  = sh_src[7];
                sh_val = {sh_src[6:0], sh_src[7]};
            end
            OP_RLA, OP_RL: begin
                sh_co  = sh_src[7];
                sh_val = {sh_src[6:0], fc};
            end
            OP_RRCA, OP_RRC: begin
                sh_co  = sh_src[0];
                sh_val = {sh_src[0], sh_src[7:1]};
            end
            OP_RRA, OP_RR: begin
                sh_co  = sh_src[0];
                sh_val = {fc, sh_src[7:1]};
            end
            OP_SLA: begin
                sh_co  = sh_src[7];
                sh_val = {sh_src[6:0], 1'b0};
            end
            OP_SRA: begin
                sh_co  = sh_src[0];
                sh_val = {sh_src[7], sh_src[7:1]};
            end
            OP_SWAP: begin
                sh_co  = 1'b0;
                sh_val = {sh_src[3:0], sh_src[7:4]};
            end
            default: begin
                sh_co  = sh_src[0];
                sh_val = {1'b0, sh_src[7:1]};
            end
        endcase
    end

    // decimal adjust; high adjust never touches the low nibble
    always_comb begin
        daa_c   = fc;
        daa_t1  = req.acc;
        daa_val = req.acc;
        if (!fn) begin
            if (fc || req.acc > DAA_HI_MAX) begin
                daa_t1 = req.acc + DAA_HI_ADJ;
                daa_c  = 1'b1;
            end
            if (fh || req.acc[3:0] > DAA_LO_MAX) begin
                daa_val = daa_t1 + DAA_LO_ADJ;
            end else begin
                daa_val = daa_t1;
            end
        end else begin
            daa_t1  = fc ? (req.acc - DAA_HI_ADJ) : req.acc;
            daa_val = fh ? (daa_t1 - DAA_LO_ADJ) : daa_t1;
        end
    end

    // result selection and flags
    always_comb begin
        res.result        = 8'd0;
        res.flags_out     = req.flags_in;
        res.writes_result = 1'b1;
        res.result_to_acc = 1'b1;
        case (req.req_type) inside
            OP_ADD, OP_ADC: begin
                res.result    = add_sum[7:0];
                res.flags_out = {add_sum[7:0] == 8'd0, 1'b0, add_half[4], add_sum[8]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                res.result    = sub_diff[7:0];
                res.flags_out = {sub_diff[7:0] == 8'd0, 1'b1, sub_half[4], sub_diff[8]};
                if (req.req_type == OP_CP) begin
                    res.writes_result = 1'b0;
                    res.result_to_acc = 1'b0;
                end
            end
            OP_AND: begin
                res.result    = req.acc & req.operand;
                res.flags_out = {(req.acc & req.operand) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR: begin
                res.result    = req.acc ^ req.operand;
                res.flags_out = {(req.acc ^ req.operand) == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            OP_OR: begin
                res.result    = req.acc | req.operand;
                res.flags_out = {(req.acc | req.operand) == 8'd0, 1'b0, 1'b0, 1'b0};
            end
            OP_INC: begin
                res.result        = inc_val;
                res.result_to_acc = 1'b0;
                res.flags_out     = {inc_val == 8'd0, 1'b0, inc_val[3:0] == 4'h0, fc};
            end
            OP_DEC: begin
                res.result        = dec_val;
                res.result_to_acc = 1'b0;
                res.flags_out     = {dec_val == 8'd0, 1'b1, dec_val[3:0] == 4'hF, fc};
            end
            [OP_RLCA:OP_RRA]: begin
                // accumulator rotates always clear Z
                res.result    = sh_val;
                res.flags_out = {1'b0, 1'b0, 1'b0, sh_co};
            end
            [OP_RLC:OP_SRL]: begin
                res.result        = sh_val;
                res.result_to_acc = 1'b0;
                res.flags_out     = {sh_val == 8'd0, 1'b0, 1'b0, sh_co};
            end
            OP_BIT: begin
                res.result        = req.operand;
                res.writes_result = 1'b0;
                res.result_to_acc = 1'b0;
                res.flags_out     = {(req.operand & bit_mask) == 8'd0, 1'b0, 1'b1, fc};
            end
            OP_RES: begin
                res.result        = req.operand & ~bit_mask;
                res.result_to_acc = 1'b0;
            end
            OP_SET: begin
                res.result        = req.operand | bit_mask;
                res.result_to_acc = 1'b0;
            end
            OP_DAA: begin
                res.result    = daa_val;
                res.flags_out = {daa_val == 8'd0, fn, 1'b0, daa_c};
            end
            OP_CPL: begin
                res.result    = ~req.acc;
                res.flags_out = {fz, 1'b1, 1'b1, fc};
            end
            OP_CCF: begin
                res.result        = req.acc;
                res.writes_result = 1'b0;
                res.result_to_acc = 1'b0;
                res.flags_out     = {fz, 1'b0, 1'b0, ~fc};
            end
            OP_SCF: begin
                res.result        = req.acc;
                res.writes_result = 1'b0;
                res.result_to_acc = 1'b0;
                res.flags_out     = {fz, 1'b0, 1'b0, 1'b1};
            end
            default: begin
                // unused codes: no-op
                res.result        = 8'd0;
                res.flags_out     = req.flags_in;
                res.writes_result = 1'b0;
                res.result_to_acc = 1'b0;
            end
        endcase
    end

endmodule

[rtl/cpu_alu_8bit_with_shift_bit_unit.sv]
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_shift_bit_unit
// 8-bit processor ALU with Z/N/H/C flags, shift and bit unit, stream ports.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel carries one operation per transaction: opcode, accumulator,
//   second operand or target byte, current flags and bit number. The m_
//   channel returns one transaction per operation: result byte, new flags,
//   a write enable and a destination select (accumulator or target).
//   From s_ acceptance to m_tvalid an operation passes one input register,
//   then the ALU logic, then the result register.
//   Throughput is one operation per cycle while m_tready stays high; the ALU
//   logic is a single pass between those two registers, so nothing iterates.
//   When the receiver stalls (m_tready low), the result register holds and
//   the input register still takes one more operation, so s_tready drops
//   only once both registers are full. Results leave in issue order.
//   aresetn (synchronous, active low) empties both registers; the block has
//   no other state and is ready again in the first cycle after reset.
// ----------------------------------------------------------------------------
module cpu_alu_8bit_with_shift_bit_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: req_type[4:0], acc[12:5], operand[20:13], flags_in[24:21],
    //          bit_index[27:25], zero[31:28]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [alu8_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: result[7:0], flags_out[11:8], writes_result[12],
    //          result_to_acc[13], zero[15:14]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [alu8_pkg::M_DATA_W-1:0] m_tdata
);
    import alu8_pkg::*;

    logic      in_valid_reg;
    logic      in_valid_next;
    alu8_req_t in_req_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    alu8_res_t out_res_reg;
    alu8_res_t alu_res;
    logic      out_load;
    logic      in_load;

    // result register takes a new transaction when empty or being drained
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_req_reg <= alu8_req_t'(s_tdata[$bits(alu8_req_t)-1:0]);
        end
    end

    alu8_core u_core (
        .req (in_req_reg),
        .res (alu_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_res_reg <= alu_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - $bits(alu8_res_t)){1'b0}}, out_res_reg};

endmodule

[tb/sv/cpu_alu_8bit_with_shift_bit_unit_tb.sv]
// ----------------------------------------------------------------------------
// cpu_alu_8bit_with_shift_bit_unit_tb
// Self-checking bench for the 8-bit ALU with shift and bit unit.
// A short list of hand-picked operations runs first. Rows whose answer is
// obvious carry it typed in; the rest are checked against a flag-accurate
// model of the ALU kept in this file. Several hundred random operations
// follow. Both stream sides pause at random, except for a calm stretch in
// the middle. Every result transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module cpu_alu_8bit_with_shift_bit_unit_tb;

    import alu8_pkg::*;

    localparam int         RANDOM_ITEMS = 650;
    localparam int         CYCLE_LIMIT  = 50000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         IDLE_PCT     = 18;
    localparam int         CALM_FIRST   = 300;
    localparam int         CALM_LAST    = 450;
    localparam int         MAX_REPORTS  = 10;
    // opcode space above SCF is unused and must behave as a no-op
    localparam logic [4:0] OP_CODE_MAX  = 5'd31;

    typedef struct {
        alu8_req_t rq;
        logic      has_lit;
        alu8_res_t res;
    } step_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // side channel: typed-in answer that travels with the current s_ transaction
    logic      s_has_lit;
    alu8_res_t s_lit_res;

    step_row_t dir_rows[$];
    alu8_res_t pending_q[$];
    int        fault_cnt = 0;
    int        sent_cnt  = 0;
    int        cycle_cnt = 0;
    logic      calm;

    byte unsigned edge_bytes[8] = '{8'h00, 8'h01, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'hFF};

    cpu_alu_8bit_with_shift_bit_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    assign calm = (sent_cnt >= CALM_FIRST) && (sent_cnt < CALM_LAST);

    // Z N H C packed into their flag positions
    function automatic logic [3:0] flags_of(logic z, logic n, logic h, logic c);
        logic [3:0] fl;
        fl         = '0;
        fl[FLAG_Z] = z;
        fl[FLAG_N] = n;
        fl[FLAG_H] = h;
        fl[FLAG_C] = c;
        return fl;
    endfunction

    // Expected ALU outcome for one operation
    function automatic alu8_res_t alu_predict(alu8_req_t rq);
        logic [7:0] a, v, r, x, t;
        logic [3:0] f, fo;
        logic [8:0] wide;
        logic [4:0] nib;
        logic       cin, cuse, co, wr, to_acc, dc;
        alu8_res_t  res;
        a      = rq.acc;
        v      = rq.operand;
        f      = rq.flags_in;
        cin    = f[FLAG_C];
        r      = '0;
        fo     = f;
        wr     = 1'b1;
        to_acc = 1'b1;
        case (rq.req_type)
            OP_ADD, OP_ADC: begin
                cuse = (rq.req_type == OP_ADC) ? cin : 1'b0;
                wide = {1'b0, a} + {1'b0, v} + {8'd0, cuse};
                nib  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cuse};
                r    = wide[7:0];
                fo   = flags_of(r == 8'h00, 1'b0, nib[4], wide[8]);
            end
            OP_SUB, OP_SBC, OP_CP: begin
                cuse = (rq.req_type == OP_SBC) ? cin : 1'b0;
                // bit 8 / bit 4 of the widened difference is the borrow
                wide = {1'b0, a} - {1'b0, v} - {8'd0, cuse};
                nib  = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cuse};
                r    = wide[7:0];
                fo   = flags_of(r == 8'h00, 1'b1, nib[4], wide[8]);
                if (rq.req_type == OP_CP) begin
                    wr     = 1'b0;
                    to_acc = 1'b0;
                end
            end
            OP_AND: begin
                r  = a & v;
                fo = flags_of(r == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            OP_XOR: begin
                r  = a ^ v;
                fo = flags_of(r == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_OR: begin
                r  = a | v;
                fo = flags_of(r == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            OP_INC: begin
                r      = v + 8'h01;
                to_acc = 1'b0;
                fo     = flags_of(r == 8'h00, 1'b0, r[3:0] == 4'h0, cin);
            end
            OP_DEC: begin
                r      = v - 8'h01;
                to_acc = 1'b0;
                fo     = flags_of(r == 8'h00, 1'b1, r[3:0] == 4'hF, cin);
            end
            OP_RLCA, OP_RLA, OP_RRCA, OP_RRA, OP_RLC, OP_RRC,
            OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
                x = (rq.req_type <= OP_RRA) ? a : v;
                case (rq.req_type)
                    OP_RLCA, OP_RLC: begin co = x[7]; r = {x[6:0], x[7]}; end
                    OP_RLA, OP_RL:   begin co = x[7]; r = {x[6:0], cin};  end
                    OP_RRCA, OP_RRC: begin co = x[0]; r = {x[0], x[7:1]}; end
                    OP_RRA, OP_RR:   begin co = x[0]; r = {cin, x[7:1]};  end
                    OP_SLA:          begin co = x[7]; r = {x[6:0], 1'b0}; end
                    OP_SRA:          begin co = x[0]; r = {x[7], x[7:1]}; end
                    OP_SWAP:         begin co = 1'b0; r = {x[3:0], x[7:4]}; end
                    default:         begin co = x[0]; r = {1'b0, x[7:1]}; end
                endcase
                // accumulator rotates always clear Z
                if (rq.req_type <= OP_RRA) begin
                    fo = flags_of(1'b0, 1'b0, 1'b0, co);
                end else begin
                    fo     = flags_of(r == 8'h00, 1'b0, 1'b0, co);
                    to_acc = 1'b0;
                end
            end
            OP_BIT: begin
                r      = v;
                wr     = 1'b0;
                to_acc = 1'b0;
                fo     = flags_of(!v[rq.bit_index], 1'b0, 1'b1, cin);
            end
            OP_RES: begin
                r      = v & ~(8'h01 << rq.bit_index);
                to_acc = 1'b0;
            end
            OP_SET: begin
                r      = v | (8'h01 << rq.bit_index);
                to_acc = 1'b0;
            end
            OP_DAA: begin
                t  = a;
                dc = cin;
                if (!f[FLAG_N]) begin
                    if (cin || t > DAA_HI_MAX) begin
                        t  = t + DAA_HI_ADJ;
                        dc = 1'b1;
                    end
                    if (f[FLAG_H] || t[3:0] > DAA_LO_MAX)
                        t = t + DAA_LO_ADJ;
                end else begin
                    if (cin)
                        t = t - DAA_HI_ADJ;
                    if (f[FLAG_H])
                        t = t - DAA_LO_ADJ;
                end
                r  = t;
                fo = flags_of(r == 8'h00, f[FLAG_N], 1'b0, dc);
            end
            OP_CPL: begin
                r  = ~a;
                fo = flags_of(f[FLAG_Z], 1'b1, 1'b1, cin);
            end
            OP_CCF, OP_SCF: begin
                r      = a;
                wr     = 1'b0;
                to_acc = 1'b0;
                fo     = flags_of(f[FLAG_Z], 1'b0, 1'b0,
                                  (rq.req_type == OP_SCF) ? 1'b1 : !cin);
            end
            default: begin
                // unused opcodes: nothing written, flags pass through
                r      = 8'h00;
                fo     = f;
                wr     = 1'b0;
                to_acc = 1'b0;
            end
        endcase
        res.result        = r;
        res.flags_out     = fo;
        res.writes_result = wr;
        res.result_to_acc = to_acc;
        return res;
    endfunction

    function automatic void add_row(logic [4:0] op, logic [7:0] a, logic [7:0] v,
                                    logic [3:0] f, logic [2:0] b, logic lit,
                                    logic [7:0] r, logic [3:0] fo, logic wr, logic ta);
        step_row_t rw;
        rw.rq.req_type          = op;
        rw.rq.acc               = a;
        rw.rq.operand           = v;
        rw.rq.flags_in          = f;
        rw.rq.bit_index         = b;
        rw.has_lit              = lit;
        rw.res.result           = r;
        rw.res.flags_out        = fo;
        rw.res.writes_result    = wr;
        rw.res.result_to_acc    = ta;
        dir_rows.push_back(rw);
    endfunction

    // mostly uniform bytes, with a bias toward carry and BCD boundaries
    function automatic logic [7:0] pick_byte();
        logic [7:0] val;
        if ($urandom_range(0, 7) == 0)
            val = edge_bytes[3'($urandom_range(0, 7))];
        else
            val = 8'($urandom_range(0, 255));
        return val;
    endfunction

    // Record accepted operations and check result transactions in order
    always @(posedge aclk) begin
        alu8_res_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                pending_q.push_back(s_has_lit ? s_lit_res
                                              : alu_predict(s_tdata[$bits(alu8_req_t)-1:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(alu8_res_t)-1:0];
                if (pending_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= MAX_REPORTS)
                        $display("unexpected result transaction: %h", got);
                end else begin
                    want = pending_q.pop_front();
                    if (got.result !== want.result || got.flags_out !== want.flags_out
                        || got.writes_result !== want.writes_result
                        || got.result_to_acc !== want.result_to_acc) begin
                        fault_cnt++;
                        if (fault_cnt <= MAX_REPORTS)
                            $display("mismatch: exp %h/%h/%b/%b got %h/%h/%b/%b",
                                     want.result, want.flags_out, want.writes_result,
                                     want.result_to_acc, got.result, got.flags_out,
                                     got.writes_result, got.result_to_acc);
                    end
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        alu8_req_t rq;
        alu8_res_t lit_res;
        logic      lit;
        int        idx;
        int        total;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_has_lit = 1'b0;
        s_lit_res = '0;

        // directed: every operation, field extremes, flag corner cases
        add_row(OP_ADD,  8'hFF, 8'h01, 4'h0, 3'd0, 1, 8'h00, 4'hB, 1, 1);
        add_row(OP_ADC,  8'hFF, 8'h00, 4'h1, 3'd0, 1, 8'h00, 4'hB, 1, 1);
        add_row(OP_SUB,  8'h00, 8'h01, 4'h0, 3'd7, 1, 8'hFF, 4'h7, 1, 1);
        add_row(OP_SBC,  8'h10, 8'h0F, 4'h1, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_AND,  8'hF0, 8'h0F, 4'h0, 3'd0, 1, 8'h00, 4'hA, 1, 1);
        add_row(OP_XOR,  8'hFF, 8'hFF, 4'hF, 3'd7, 1, 8'h00, 4'h8, 1, 1);
        add_row(OP_OR,   8'h00, 8'h00, 4'hF, 3'd0, 1, 8'h00, 4'h8, 1, 1);
        add_row(OP_CP,   8'h42, 8'h42, 4'h0, 3'd0, 1, 8'h00, 4'hC, 0, 0);
        add_row(OP_INC,  8'h00, 8'hFF, 4'h1, 3'd0, 1, 8'h00, 4'hB, 1, 0);
        add_row(OP_DEC,  8'h00, 8'h00, 4'h0, 3'd0, 1, 8'hFF, 4'h6, 1, 0);
        add_row(OP_RLCA, 8'h80, 8'h00, 4'hF, 3'd0, 1, 8'h01, 4'h1, 1, 1);
        add_row(OP_RLA,  8'h55, 8'h00, 4'h1, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RRCA, 8'h01, 8'h00, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RRA,  8'hFF, 8'h00, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RLC,  8'h00, 8'h00, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RRC,  8'h00, 8'h81, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RL,   8'h00, 8'h80, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_RR,   8'h00, 8'h01, 4'h1, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_SLA,  8'h00, 8'h80, 4'h0, 3'd0, 1, 8'h00, 4'h9, 1, 0);
        add_row(OP_SRA,  8'h00, 8'h81, 4'h0, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_SWAP, 8'h00, 8'hF0, 4'hF, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_SRL,  8'h00, 8'h01, 4'h0, 3'd0, 1, 8'h00, 4'h9, 1, 0);
        add_row(OP_BIT,  8'h00, 8'h7F, 4'h0, 3'd7, 1, 8'h7F, 4'hA, 0, 0);
        add_row(OP_RES,  8'h00, 8'hFF, 4'h5, 3'd0, 1, 8'hFE, 4'h5, 1, 0);
        add_row(OP_SET,  8'h00, 8'h00, 4'hF, 3'd7, 1, 8'h80, 4'hF, 1, 0);
        // decimal adjust after add (both corrections) and after subtract
        add_row(OP_DAA,  8'h9A, 8'h00, 4'h0, 3'd0, 1, 8'h00, 4'h9, 1, 1);
        add_row(OP_DAA,  8'h00, 8'h00, 4'h7, 3'd0, 0, 8'h00, 4'h0, 0, 0);
        add_row(OP_CPL,  8'h00, 8'h00, 4'h0, 3'd0, 1, 8'hFF, 4'h6, 1, 1);
        add_row(OP_CCF,  8'h55, 8'h00, 4'h9, 3'd0, 1, 8'h55, 4'h8, 0, 0);
        add_row(OP_SCF,  8'hAA, 8'h00, 4'h6, 3'd0, 1, 8'hAA, 4'h1, 0, 0);
        add_row(OP_CODE_MAX, 8'hFF, 8'hFF, 4'hA, 3'd7, 1, 8'h00, 4'hA, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        total = dir_rows.size() + RANDOM_ITEMS;
        for (idx = 0; idx < total; idx++) begin
            if (idx < dir_rows.size()) begin
                rq      = dir_rows[idx].rq;
                lit     = dir_rows[idx].has_lit;
                lit_res = dir_rows[idx].res;
            end else begin
                // a few unused opcodes mixed into the defined ones
                if ($urandom_range(0, 99) < 5)
                    rq.req_type = 5'($urandom_range(OP_SCF + 1, OP_CODE_MAX));
                else
                    rq.req_type = 5'($urandom_range(OP_ADD, OP_SCF));
                rq.acc       = pick_byte();
                rq.operand   = pick_byte();
                rq.flags_in  = 4'($urandom_range(0, 15));
                rq.bit_index = 3'($urandom_range(0, 7));
                lit          = 1'b0;
                lit_res      = '0;
            end
            s_tvalid  <= 1'b1;
            s_tdata   <= {{(S_DATA_W - $bits(alu8_req_t)){1'b0}}, rq};
            s_has_lit <= lit;
            s_lit_res <= lit_res;
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            sent_cnt++;
            // random sender gap with s_tvalid low
            if (!calm && $urandom_range(0, 99) < 15) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fault_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
